// ----- design/task_queue_keyed_remove_macros.svh -----
// assertion macros for the task queue datapath rtl
// uses clk_i and rst_ni of the module that includes it
`ifndef TASK_QUEUE_KEYED_REMOVE_MACROS_SVH
`define TASK_QUEUE_KEYED_REMOVE_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge out of reset
`define TQKR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tqkr assertion failed");
// implication checked on every rising clock edge out of reset
`define TQKR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tqkr implication failed");
`else
`define TQKR_ASSERT(lbl, prop)
`define TQKR_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ----- design/tqkr_pkg.sv -----
// shared types and codes for the task queue with keyed removal
// no dependencies
package tqkr_pkg;

  localparam int unsigned ID_W   = 22;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned INFO_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_UPD = 2'd2;
  localparam logic [OP_W-1:0] OP_REM = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  // task states
  localparam logic [ST_W-1:0] TASK_READY   = 2'd0;
  localparam logic [ST_W-1:0] TASK_RUNNING = 2'd1;

  // write data selects
  localparam logic [1:0] WSEL_ENQ   = 2'd0;
  localparam logic [1:0] WSEL_UPD   = 2'd1;
  localparam logic [1:0] WSEL_SHIFT = 2'd2;

  typedef struct packed {
    logic [INFO_W-1:0] info;
    logic [ST_W-1:0]   state;
    logic [ID_W-1:0]   id;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              mem_we;
    logic [1:0]        wsel;
    logic              rd_next;
    logic              idx_inc;
    logic              count_inc;
    logic              count_dec;
    logic              take_head;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            match;
    logic            has_next;
    logic            out_free;
  } sts_t;

endpackage

// ----- design/task_queue_keyed_remove.sv -----
// top level of the ordered task queue with keyed removal
// depends on tqkr_pkg, tqkr_ctrl and tqkr_dp
//
// usage
// - one request transaction on the s_axis side yields exactly one result
//   transaction on the m_axis side, in request order
// - tuser carries the operation (enqueue, dequeue head, update state by id,
//   remove by id) on the way in and the status code on the way out
// - requests are taken one at a time: s_axis_tready_o is high only while
//   the sequencer is idle, so the next request waits until the last result is loaded
// - enqueue and any request that fails at once go straight to the result;
//   dequeue takes the head and shifts the entries behind it up, update scans
//   from the head to the first match, remove scans to the match and then shifts
//   the entries behind it up; scan and shift step through the entry memory
//   with one read port and one write port
// - results sit in an output register; a stalled receiver holds the
//   result there and the next request is already accepted and worked on,
//   only its result waits until the register frees
// - reset clears the entry count, scan index and result valid flag; entry
//   memory contents are left as they are and never used until written
module task_queue_keyed_remove #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // task_id[21:0], set_state[23:22], task_info[55:24]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // out_id[21:0], out_state[23:22], out_info[55:24],
                                        // occupancy[60:56], zero[63:61]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import tqkr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [ID_W-1:0]   out_id;
  logic [ST_W-1:0]   out_state;
  logic [INFO_W-1:0] out_info;
  logic [OCC_W-1:0]  occupancy;

  // sequencer: walks each request through check, scan and shift steps
  tqkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: entry memory, count, search key and result register
  tqkr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser_i),
    .task_id_i   (s_axis_tdata_i[21:0]),
    .set_state_i (s_axis_tdata_i[23:22]),
    .task_info_i (s_axis_tdata_i[55:24]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .status_o    (m_axis_tuser_o),
    .out_id_o    (out_id),
    .out_state_o (out_state),
    .out_info_o  (out_info),
    .occupancy_o (occupancy)
  );

  // pack result fields, lowest field first, padded to whole bytes
  assign m_axis_tdata_o = {3'b000, occupancy, out_info, out_state, out_id};

endmodule

// ----- design/tqkr_ctrl.sv -----
// sequencing state machine for the task queue
// depends on tqkr_pkg for command and status structs
module tqkr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tqkr_pkg::sts_t sts_i,
  output tqkr_pkg::cmd_t cmd_o
);
  import tqkr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_SHR  = 3'd5;
  localparam logic [2:0] S_SHW  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_ENQ: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STAT_FULL;
            end else begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.wsel      = WSEL_ENQ;
              cmd_o.count_inc = 1'b1;
            end
            state_d = S_DONE;
          end
          OP_DEQ: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STAT_EMPTY;
              state_d          = S_DONE;
            end else begin
              state_d = S_HEAD;
            end
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STAT_NOT_FOUND;
              state_d          = S_DONE;
            end else begin
              state_d = S_CMP;
            end
          end
        endcase
      end
      S_HEAD: begin
        cmd_o.take_head = 1'b1;
        state_d         = S_SHR;
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.match) begin
          if (sts_i.op == OP_UPD) begin
            cmd_o.mem_we = 1'b1;
            cmd_o.wsel   = WSEL_UPD;
            state_d      = S_DONE;
          end else begin
            state_d = S_SHR;
          end
        end else if (sts_i.has_next) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_NOT_FOUND;
          state_d          = S_DONE;
        end
      end
      S_SHR: begin
        if (sts_i.has_next) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHW;
        end else begin
          cmd_o.count_dec = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_SHW: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = WSEL_SHIFT;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SHR;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/tqkr_dp.sv -----
// entry memory, scan index, count, request and result registers
// depends on tqkr_pkg and the assertion macro header
`include "task_queue_keyed_remove_macros.svh"

module tqkr_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tqkr_pkg::cmd_t                cmd_i,
  output tqkr_pkg::sts_t                sts_o,
  input  logic [tqkr_pkg::OP_W-1:0]     op_i,
  input  logic [tqkr_pkg::ID_W-1:0]     task_id_i,
  input  logic [tqkr_pkg::ST_W-1:0]     set_state_i,
  input  logic [tqkr_pkg::INFO_W-1:0]   task_info_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tqkr_pkg::STAT_W-1:0]   status_o,
  output logic [tqkr_pkg::ID_W-1:0]     out_id_o,
  output logic [tqkr_pkg::ST_W-1:0]     out_state_o,
  output logic [tqkr_pkg::INFO_W-1:0]   out_info_o,
  output logic [tqkr_pkg::OCC_W-1:0]    occupancy_o
);
  import tqkr_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t entry_mem_q [QUEUE_DEPTH];
  entry_t rdata_q;
  entry_t wdata;
  logic [IW-1:0] raddr, waddr;

  logic [IW-1:0] idx_q;
  logic [CW-1:0] count_q;

  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   key_id_q;
  logic [ST_W-1:0]   set_state_q;
  logic [INFO_W-1:0] info_q;

  logic [STAT_W-1:0] res_status_q;
  logic [ID_W-1:0]   res_id_q;
  logic [ST_W-1:0]   res_state_q;
  logic [INFO_W-1:0] res_info_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [ID_W-1:0]   out_id_q;
  logic [ST_W-1:0]   out_state_q;
  logic [INFO_W-1:0] out_info_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic has_next;

  assign has_next = ((CW + 1)'(idx_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
  assign raddr    = cmd_i.rd_next ? (idx_q + IW'(1)) : idx_q;

  always_comb begin
    case (cmd_i.wsel)
      WSEL_ENQ: begin
        waddr       = count_q[IW-1:0];
        wdata.info  = info_q;
        wdata.state = TASK_READY;
        wdata.id    = key_id_q;
      end
      WSEL_UPD: begin
        waddr       = idx_q;
        wdata       = rdata_q;
        wdata.state = set_state_q;
      end
      default: begin
        waddr = idx_q;
        wdata = rdata_q;
      end
    endcase
  end

  // entry storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      entry_mem_q[waddr] <= wdata;
    end
    rdata_q <= entry_mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q         <= op_i;
      key_id_q     <= task_id_i;
      set_state_q  <= set_state_i;
      info_q       <= task_info_i;
      res_status_q <= STAT_OK;
      res_id_q     <= '0;
      res_state_q  <= '0;
      res_info_q   <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.take_head) begin
        res_id_q    <= rdata_q.id;
        res_state_q <= TASK_RUNNING;
        res_info_q  <= rdata_q.info;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_state_q  <= res_state_q;
      out_info_q   <= res_info_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(QUEUE_DEPTH));
  assign sts_o.match    = (rdata_q.id == key_id_q);
  assign sts_o.has_next = has_next;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_id_o    = out_id_q;
  assign out_state_o = out_state_q;
  assign out_info_o  = out_info_q;
  assign occupancy_o = out_occ_q;

  `TQKR_ASSERT(a_count_max, count_q <= CW'(QUEUE_DEPTH))
  `TQKR_ASSERT_IMP(a_inc_not_full, cmd_i.count_inc, count_q < CW'(QUEUE_DEPTH))
  `TQKR_ASSERT_IMP(a_dec_not_empty, cmd_i.count_dec, count_q != '0)
  `TQKR_ASSERT_IMP(a_shift_in_range, cmd_i.rd_next, has_next)
  `TQKR_ASSERT_IMP(a_load_when_free, cmd_i.load_out, !out_valid_q || out_ready_i)

endmodule

// ----- tb/sv/tb_task_queue_keyed_remove.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the ordered task queue with keyed removal
// depends on tqkr_pkg and task_queue_keyed_remove; predicts every result from a
// queue model of its own and checks the result stream field by field
module tb_task_queue_keyed_remove;
  import tqkr_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TAIL      = 4 * DEPTH + 16;   // worst scan and shift plus margin
  localparam int unsigned MAX_CYCLE = 600000;
  localparam int unsigned N_RANDOM  = 550;
  localparam logic [ID_W-1:0]   ID_MAX   = '1;
  localparam logic [INFO_W-1:0] INFO_MAX = '1;

  // one result transaction, unpacked
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [ST_W-1:0]   out_state;
    logic [INFO_W-1:0] out_info;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // task_id[21:0], set_state[23:22], task_info[55:24]
  logic [1:0]  s_tuser = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // out_id[21:0], out_state[23:22], out_info[55:24],
                               // occupancy[60:56], zero[63:61]
  logic [1:0]  m_tuser;        // status[1:0]

  // own copy of the queue contents, head at index 0
  entry_t  task_model[$];
  // results still owed by the block, oldest first
  result_t pending_results[$];

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 1;

  // receiver stall pattern
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold = 0;

  result_t got_res;
  result_t want_res;

  task_queue_keyed_remove #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // applies one request to the queue model and returns the result it owes
  function automatic result_t apply_request(input logic [OP_W-1:0] op,
                                            input logic [ID_W-1:0] id,
                                            input logic [ST_W-1:0] nst,
                                            input logic [INFO_W-1:0] info);
    result_t r;
    entry_t  e;
    int      pos;
    r.status    = STAT_OK;
    r.out_id    = '0;
    r.out_state = '0;
    r.out_info  = '0;
    pos = -1;
    case (op)
      OP_ENQ: begin
        // full queue drops the new task
        if (task_model.size() >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          e.id    = id;
          e.state = TASK_READY;
          e.info  = info;
          task_model.push_back(e);
        end
      end
      OP_DEQ: begin
        if (task_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          e = task_model.pop_front();
          r.out_id    = e.id;
          r.out_state = TASK_RUNNING;
          r.out_info  = e.info;
        end
      end
      default: begin
        // only the first match in queue order counts
        foreach (task_model[i]) begin
          if (pos < 0 && task_model[i].id == id) pos = i;
        end
        if (pos < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (op == OP_UPD) begin
          task_model[pos].state = nst;
        end else begin
          task_model.delete(pos);   // later entries move up, order kept
        end
      end
    endcase
    r.occupancy = OCC_W'(task_model.size());
    return r;
  endfunction

  // one request transaction; the sender idles between bursts of random length
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [ST_W-1:0] nst, input logic [INFO_W-1:0] info);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {info, nst, id};
    do @(posedge clk_i); while (!s_tready);
    pending_results.push_back(apply_request(op, id, nst, info));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
  endtask

  // waits until every owed result has come, then lets the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // empty queue: dequeue flags empty, update finds nothing
  task automatic test_empty_queue();
    send_request(OP_DEQ, ID_MAX, 2'd3, INFO_MAX);
    send_request(OP_UPD, '0, 2'd1, '0);
    wait_drained();
  endtask

  // extreme ids and payloads, duplicate ids, first-match rules, misses
  task automatic test_match_order();
    send_request(OP_ENQ, '0, 2'd0, '0);
    send_request(OP_ENQ, ID_MAX, 2'd3, INFO_MAX);
    send_request(OP_ENQ, '0, 2'd2, 32'ha5a5_5a5a);   // duplicate of the head id
    send_request(OP_UPD, '0, 2'd3, 32'h0000_ffff);   // hits the head only
    send_request(OP_REM, '0, 2'd0, '0);              // removes the head, duplicate stays
    send_request(OP_REM, 22'h155555, 2'd1, '0);      // miss on a non-empty queue
    send_request(OP_DEQ, 22'h2aaaaa, 2'd2, '0);      // returns the max id entry
    wait_drained();
  endtask

  // fill to the top, overflow, then remove from the middle of a full queue
  task automatic test_full_queue();
    for (int i = task_model.size(); i < DEPTH; i++) begin
      send_request(OP_ENQ, ID_W'(100 + i), 2'(i), {16'hc0de, 16'(i)});
    end
    send_request(OP_ENQ, 22'h3fff00, 2'd0, 32'hdead_beef);
    send_request(OP_REM, 22'd107, 2'd0, '0);
    wait_drained();
  endtask

  // random operation mixes: filling, draining and balanced phases, with ids
  // mostly taken from the queue so that updates and removals hit
  task automatic test_random_mix();
    logic [ID_W-1:0]   pool [6];
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [INFO_W-1:0] info;
    int unsigned       phase;
    int unsigned       r;
    foreach (pool[i]) pool[i] = ID_W'($urandom_range(0, 2**ID_W - 1));
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n / 45) % 3;
      r = $urandom_range(0, 99);
      case (phase)
        0:       op = (r < 55) ? OP_ENQ : (r < 65) ? OP_DEQ : (r < 80) ? OP_UPD : OP_REM;
        1:       op = (r < 15) ? OP_ENQ : (r < 60) ? OP_DEQ : (r < 75) ? OP_UPD : OP_REM;
        default: op = (r < 30) ? OP_ENQ : (r < 55) ? OP_DEQ : (r < 75) ? OP_UPD : OP_REM;
      endcase
      // id: an entry already queued, a pool id (duplicates), or anything
      r = $urandom_range(0, 99);
      if (op != OP_ENQ && task_model.size() != 0 && r < 70) begin
        id = task_model[$urandom_range(0, task_model.size() - 1)].id;
      end else if (r < 85) begin
        id = pool[$urandom_range(0, 5)];
      end else begin
        id = ID_W'($urandom_range(0, 2**ID_W - 1));
      end
      case ($urandom_range(0, 15))
        0:       info = '0;
        1:       info = INFO_MAX;
        default: info = $urandom;
      endcase
      send_request(op, id, 2'($urandom_range(0, 3)), info);
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    burst_left = $urandom_range(1, 16);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty_queue();
    test_match_order();
    test_full_queue();
    test_random_mix();
    if (err_cnt == 0) begin
      $display("** task_queue_keyed_remove: PASSED **");
    end else begin
      $display("** task_queue_keyed_remove: FAILED **");
    end
    $finish;
  end

  // receiver: always ready, light random stalls, or long stall stretches
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(64, 256);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 16);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // result checker: every accepted transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding: tdata 0x%0h, tuser %0d",
               m_tdata, m_tuser);
        err_cnt++;
      end else begin
        want_res = pending_results.pop_front();
        got_res.status    = m_tuser;
        got_res.out_id    = m_tdata[21:0];
        got_res.out_state = m_tdata[23:22];
        got_res.out_info  = m_tdata[55:24];
        got_res.occupancy = m_tdata[60:56];
        check_field("status", want_res.status, got_res.status);
        check_field("out_id", want_res.out_id, got_res.out_id);
        check_field("out_state", want_res.out_state, got_res.out_state);
        check_field("out_info", want_res.out_info, got_res.out_info);
        check_field("occupancy", want_res.occupancy, got_res.occupancy);
        check_field("tdata pad", '0, m_tdata[63:61]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("** task_queue_keyed_remove: FAILED **");
      $finish;
    end
  end

endmodule
